@@ sv/glcd_pkg.sv @@
// Shared constants and types of the graphic panel frame buffer controller.
package glcd_pkg;

    localparam int PAGES     = 8;
    localparam int COLUMNS   = 128;
    localparam int ROW_BITS  = 8;
    localparam int HALF_COLS = COLUMNS / 2;

    localparam int PAGE_W   = $clog2(PAGES);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int LANE_W   = 3;
    localparam int LANES    = 1 << LANE_W;
    localparam int WADDR_W  = PAGE_W + COL_W - LANE_W;
    localparam int WORDS    = 1 << WADDR_W;
    localparam int WORD_W   = LANES * ROW_BITS;
    localparam int HALF_W   = $clog2(HALF_COLS);

    localparam logic [7:0] CMD_PAGE   = 8'hB8;
    localparam logic [7:0] CMD_COLUMN = 8'h40;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_PIXEL  = 2'd1,
        MODE_COLUMN = 2'd2,
        MODE_TICK   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_TRD,
        S_OPG,
        S_OCOL,
        S_ODAT
    } t_state;

endpackage

@@ sv/graphic_lcd_framebuffer_refresh_top.sv @@
// Top level of the graphic panel frame buffer controller with refresh scan.
//
//  Channel | Direction | Handshake         | Payload
//  --------+-----------+-------------------+---------------------------------------------
//  input   | in        | i_valid / o_stall | i_mode, i_x_position, i_y_position,
//          |           |                   | i_pixel_data, i_bit_count, i_refresh_request
//  output  | out       | o_valid / i_stall | o_is_data, o_select_right, o_bus_byte,
//          |           |                   | o_last, o_frame_done
//
// One transaction at a time. A clear drops all 128 word valid bits at once, so no clearing pass
// is needed, and restarts the scan. A pixel or column write covers a pair of pages: for each page,
// a read-modify-write of a 64-bit word (read state, then write state), or only the read state when
// the page is untouched. A running-scan tick takes a read state plus three output transactions
// (page, column, data); an idle tick issues no output. Reset clears the valid bits and the scan
// state, and o_stall is high whenever the sequencer is not idle.
module graphic_lcd_framebuffer_refresh_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_x_position,
    input  logic [7:0] i_y_position,
    input  logic [7:0] i_pixel_data,
    input  logic [3:0] i_bit_count,
    input  logic       i_refresh_request,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_is_data,
    output logic       o_select_right,
    output logic [7:0] o_bus_byte,
    output logic       o_last,
    output logic       o_frame_done
);
    import glcd_pkg::*;

    t_state r_state, n_state;

    logic [WORDS-1:0]  r_vld, n_vld;
    logic              r_scan_active, n_scan_active;
    logic [PAGE_W-1:0] r_scan_page, n_scan_page;
    logic [COL_W-1:0]  r_scan_col, n_scan_col;

    logic [15:0] r_mask, n_mask;
    logic [15:0] r_wdata, n_wdata;
    logic [4:0]  r_page, n_page;
    logic [7:0]  r_x, n_x;
    logic        r_hi, n_hi;
    logic        r_refresh, n_refresh;
    logic        r_wvalid, n_wvalid;

    logic               in_acc, out_acc;
    t_mode              mode;
    logic [3:0]         cnt;
    logic [7:0]         m8, d8;
    logic [5:0]         page_cur;
    logic               wr_ok;
    logic [7:0]         mb, db;
    logic [WADDR_W-1:0] wr_addr, scan_addr;
    logic [WORD_W-1:0]  base, new_word;
    logic [7:0]         old_byte, scan_byte;
    logic               scan_last;

    logic               ram_we, ram_re;
    logic [WADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign mode    = t_mode'(i_mode);

    // Operand shaping: a set pixel is a one-bit column write of the OR of the data byte.
    always_comb begin
        cnt = (mode == MODE_PIXEL) ? 4'd1 : ((i_bit_count > 4'd8) ? 4'd8 : i_bit_count);
        for (int i = 0; i < 8; i++) begin
            m8[i] = (4'(i) < cnt);
        end
        d8 = (mode == MODE_PIXEL) ? {7'd0, |i_pixel_data} : (i_pixel_data & m8);
    end

    assign page_cur  = {1'b0, r_page} + {5'd0, r_hi};
    assign mb        = r_hi ? r_mask[15:8] : r_mask[7:0];
    assign db        = r_hi ? r_wdata[15:8] : r_wdata[7:0];
    assign wr_ok     = (page_cur < 6'(PAGES)) && (r_x < 8'(COLUMNS)) && (mb != 8'd0);
    assign wr_addr   = {page_cur[PAGE_W-1:0], r_x[COL_W-1:LANE_W]};
    assign scan_addr = {r_scan_page, r_scan_col[COL_W-1:LANE_W]};
    assign scan_last = (r_scan_page == PAGE_W'(PAGES - 1))
                    && (r_scan_col == COL_W'(COLUMNS - 1));

    // A word whose valid bit is low reads as all zeros.
    assign base      = r_wvalid ? ram_rdata : '0;
    assign old_byte  = base[{r_x[LANE_W-1:0], 3'b000} +: 8];
    assign scan_byte = ~base[{r_scan_col[LANE_W-1:0], 3'b000} +: 8];

    always_comb begin
        new_word = base;
        new_word[{r_x[LANE_W-1:0], 3'b000} +: 8] = (old_byte & ~mb) | (db & mb);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (mode) inside
                        MODE_CLEAR:              n_state = S_IDLE;
                        MODE_PIXEL, MODE_COLUMN: n_state = S_RD;
                        MODE_TICK:               n_state = r_scan_active ? S_TRD : S_IDLE;
                        default:                 n_state = S_IDLE;
                    endcase
                end
            end
            S_RD: begin
                if (wr_ok) begin
                    n_state = S_WR;
                end else if (r_hi) begin
                    n_state = S_IDLE;
                end
            end
            S_WR:    n_state = r_hi ? S_IDLE : S_RD;
            S_TRD:   n_state = S_OPG;
            S_OPG:   n_state = out_acc ? S_OCOL : S_OPG;
            S_OCOL:  n_state = out_acc ? S_ODAT : S_OCOL;
            S_ODAT:  n_state = out_acc ? S_IDLE : S_ODAT;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath register updates.
    always_comb begin
        n_vld         = r_vld;
        n_scan_active = r_scan_active;
        n_scan_page   = r_scan_page;
        n_scan_col    = r_scan_col;
        n_mask        = r_mask;
        n_wdata       = r_wdata;
        n_page        = r_page;
        n_x           = r_x;
        n_hi          = r_hi;
        n_refresh     = r_refresh;
        n_wvalid      = r_wvalid;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_mask    = {8'd0, m8} << i_y_position[2:0];
                    n_wdata   = {8'd0, d8} << i_y_position[2:0];
                    n_page    = i_y_position[7:3];
                    n_x       = i_x_position;
                    n_hi      = 1'b0;
                    n_refresh = i_refresh_request;
                    if (mode == MODE_CLEAR) begin
                        n_vld         = '0;
                        n_scan_active = 1'b1;
                        n_scan_page   = '0;
                        n_scan_col    = '0;
                    end
                end
            end
            S_RD: begin
                n_wvalid = r_vld[wr_addr];
                if (!wr_ok) begin
                    n_hi = 1'b1;
                end
            end
            S_WR: begin
                n_vld[wr_addr] = 1'b1;
                n_hi           = 1'b1;
            end
            S_TRD: begin
                n_wvalid = r_vld[scan_addr];
            end
            S_ODAT: begin
                if (out_acc) begin
                    if (r_scan_col == COL_W'(COLUMNS - 1)) begin
                        n_scan_col = '0;
                        if (r_scan_page == PAGE_W'(PAGES - 1)) begin
                            n_scan_page   = '0;
                            n_scan_active = 1'b0;
                        end else begin
                            n_scan_page = r_scan_page + 1'b1;
                        end
                    end else begin
                        n_scan_col = r_scan_col + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        // The write finishes after the second page of its pair; a refresh request then restarts the scan.
        if (r_refresh && (((r_state == S_RD) && !wr_ok && r_hi) || ((r_state == S_WR) && r_hi)))
        begin
            n_scan_active = 1'b1;
            n_scan_page   = '0;
            n_scan_col    = '0;
        end
    end

    // Outputs and memory controls.
    always_comb begin
        o_stall        = (r_state != S_IDLE);
        o_valid        = 1'b0;
        o_is_data      = 1'b0;
        o_select_right = r_scan_col[COL_W-1];
        o_bus_byte     = 8'd0;
        o_last         = 1'b0;
        o_frame_done   = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = wr_addr;
        unique case (r_state)
            S_IDLE: begin
            end
            S_RD: begin
                ram_re = wr_ok;
            end
            S_WR: begin
                ram_we = 1'b1;
            end
            S_TRD: begin
                ram_re    = 1'b1;
                ram_raddr = scan_addr;
            end
            S_OPG: begin
                o_valid    = 1'b1;
                o_bus_byte = CMD_PAGE | 8'(r_scan_page);
            end
            S_OCOL: begin
                o_valid    = 1'b1;
                o_bus_byte = CMD_COLUMN | 8'(r_scan_col[HALF_W-1:0]);
            end
            S_ODAT: begin
                o_valid      = 1'b1;
                o_is_data    = 1'b1;
                o_bus_byte   = scan_byte;
                o_last       = 1'b1;
                o_frame_done = scan_last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_vld         <= '0;
            r_scan_active <= 1'b0;
            r_scan_page   <= '0;
            r_scan_col    <= '0;
        end else begin
            r_state       <= n_state;
            r_vld         <= n_vld;
            r_scan_active <= n_scan_active;
            r_scan_page   <= n_scan_page;
            r_scan_col    <= n_scan_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask    <= n_mask;
        r_wdata   <= n_wdata;
        r_page    <= n_page;
        r_x       <= n_x;
        r_hi      <= n_hi;
        r_refresh <= n_refresh;
        r_wvalid  <= n_wvalid;
    end

    glcd_ram #(
        .WIDTH(WORD_W),
        .DEPTH(WORDS)
    ) u_fb_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(wr_addr),
        .i_wdata(new_word),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    a_no_input_while_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input accepted while a bus transaction is pending");

    a_scan_ends_on_frame_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_frame_done) |=> !r_scan_active)
        else $error("scan still active after the final byte of the frame");

    a_idle_tick_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (mode == MODE_TICK) && !r_scan_active) |=> (r_state == S_IDLE))
        else $error("tick without an active scan started bus output");

    a_clear_restarts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (mode == MODE_CLEAR)) |=>
            (r_scan_active && (r_scan_col == '0) && (r_scan_page == '0) && (r_vld == '0)))
        else $error("clear did not empty the buffer and restart the scan");

endmodule

@@ sv/glcd_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module glcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
